[src/urm_pkg.sv]
// Shared types and constants for the ultrasonic range measurement unit.
`timescale 1ns / 1ps
`default_nettype none

package urm_pkg;

    // Field widths
    localparam int SETTLE_W    = 24;
    localparam int TRIG_W      = 16;
    localparam int PERIOD_W    = 8;
    localparam int SCALE_W     = 16;
    localparam int DIST_W      = 16;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd3;

    // Register values after reset
    localparam logic [SETTLE_W-1:0] SETTLE_RST  = 24'd7500050;
    localparam logic [TRIG_W-1:0]   TRIGGER_RST = 16'd751;
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 8'd4;
    localparam logic [SCALE_W-1:0]  SCALE_RST   = 16'd770;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle_ticks;
        logic [TRIG_W-1:0]   trigger_ticks;
        logic [PERIOD_W-1:0] count_period_ticks;
        logic [SCALE_W-1:0]  scale_q16;
    } t_cfg;

    // Per-tick status that rides along the pipeline
    typedef struct packed {
        logic trigger_level;
        logic busy_res;
        logic done_res;
    } t_flags;

endpackage

`default_nettype wire

[src/urm_seq.sv]
// Measurement sequencer: settle, trigger, echo timing and sample summing.
`timescale 1ns / 1ps
`default_nettype none

module urm_seq
    import urm_pkg::*;
#(
    parameter int SAMPLES    = 3,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_accept,
    input  wire logic                    i_start_req,
    input  wire logic                    i_echo_level,
    input  wire t_cfg                    i_cfg,
    output logic                         o_vld,
    output t_flags                       o_flags,
    output logic [COUNT_BITS+1:0]        o_sum
);

    localparam int SUM_W = COUNT_BITS + 2;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [1:0] SAMPLES_C = 2'(SAMPLES);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_TRIGGER,
        PH_WAIT_RISE,
        PH_COUNT
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [SETTLE_W-1:0]   r_timer, n_timer;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [1:0]            r_idx, n_idx;

    logic                  r_a_vld;
    t_flags                r_a_flags;
    logic [SUM_W-1:0]      r_a_sum;

    logic                  trig;
    logic                  done;
    logic                  counting;
    logic [SETTLE_W-1:0]   cur_timer;
    logic [COUNT_BITS-1:0] c_cur;
    logic [SETTLE_W-1:0]   timer_inc;
    logic [SETTLE_W-1:0]   cur_timer_inc;
    logic [1:0]            idx_inc;

    assign timer_inc     = r_timer + 1'b1;
    assign cur_timer_inc = cur_timer + 1'b1;
    assign idx_inc       = r_idx + 2'd1;

    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_count   = r_count;
        n_sum     = r_sum;
        n_idx     = r_idx;
        trig      = 1'b0;
        done      = 1'b0;
        counting  = 1'b0;
        cur_timer = r_timer;
        c_cur     = r_count;

        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase = PH_SETTLE;
                    n_timer = '0;
                    n_sum   = '0;
                    n_idx   = '0;
                    n_count = '0;
                end
            end
            PH_SETTLE: begin
                if (r_timer >= i_cfg.settle_ticks) begin
                    n_phase = PH_TRIGGER;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_TRIGGER: begin
                trig = 1'b1;
                if (timer_inc >= SETTLE_W'(i_cfg.trigger_ticks)) begin
                    n_phase = PH_WAIT_RISE;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_WAIT_RISE: begin
                // rising echo is counted on the same tick
                if (i_echo_level) begin
                    counting  = 1'b1;
                    cur_timer = '0;
                    c_cur     = '0;
                end
            end
            PH_COUNT: begin
                counting = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (counting) begin
            if (i_echo_level) begin
                n_phase = PH_COUNT;
                // first tick of each period bumps the count, saturating
                if (cur_timer == '0 && c_cur != COUNT_MAX) begin
                    n_count = c_cur + 1'b1;
                end else begin
                    n_count = c_cur;
                end
                // zero period behaves as one
                n_timer = (cur_timer_inc >= SETTLE_W'(i_cfg.count_period_ticks)) ? '0
                                                                                  : cur_timer_inc;
            end else begin
                n_sum   = r_sum + SUM_W'(c_cur);
                n_idx   = idx_inc;
                n_timer = '0;
                if (idx_inc >= SAMPLES_C) begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                    n_idx   = '0;
                end else begin
                    n_phase = PH_TRIGGER;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
            r_a_vld   <= 1'b0;
            r_a_flags <= '0;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_timer <= n_timer;
                r_count <= n_count;
                r_sum   <= n_sum;
                r_idx   <= n_idx;
            end
            if (i_en) begin
                r_a_vld                 <= i_accept;
                r_a_flags.trigger_level <= trig;
                r_a_flags.busy_res      <= (n_phase != PH_IDLE);
                r_a_flags.done_res      <= done;
                r_a_sum                 <= n_sum;
            end
        end
    end

    assign o_vld   = r_a_vld;
    assign o_flags = r_a_flags;
    assign o_sum   = r_a_sum;

endmodule

`default_nettype wire

[src/urm_dist.sv]
// Distance arithmetic: average by reciprocal multiply, Q16 scale, saturation.
`timescale 1ns / 1ps
`default_nettype none

module urm_dist
    import urm_pkg::*;
#(
    parameter int SAMPLES    = 3,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire t_flags                i_flags,
    input  wire logic [COUNT_BITS+1:0] i_sum,
    input  wire logic [SCALE_W-1:0]    i_scale_q16,
    output logic                       o_vld,
    output t_flags                     o_flags,
    output logic [DIST_W-1:0]          o_dist
);

    localparam int SUM_W   = COUNT_BITS + 2;
    // two spare bits keep ceil(2^SHIFT / SAMPLES) exact for SAMPLES <= 3
    localparam int SHIFT   = SUM_W + 2;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int SCL_W   = SUM_W + SCALE_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    logic [PROD_W-1:0] quot_prod;
    logic [SCL_W-1:0]  scl_prod;

    logic              r_b_vld;
    t_flags            r_b_flags;
    logic [SUM_W-1:0]  r_b_avg;
    logic              r_c_vld;
    t_flags            r_c_flags;
    logic [SCL_W-1:0]  r_c_prod;

    assign quot_prod = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign scl_prod  = SCL_W'(r_b_avg) * SCL_W'(i_scale_q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_b_flags <= '0;
            r_c_vld   <= 1'b0;
            r_c_flags <= '0;
        end else if (i_en) begin
            r_b_vld   <= i_vld;
            r_b_flags <= i_flags;
            r_b_avg   <= quot_prod[SHIFT +: SUM_W];
            r_c_vld   <= r_b_vld;
            r_c_flags <= r_b_flags;
            r_c_prod  <= scl_prod;
        end
    end

    assign o_vld   = r_c_vld;
    assign o_flags = r_c_flags;
    assign o_dist  = (|r_c_prod[SCL_W-1:SCALE_W+DIST_W]) ? '1
                                                          : r_c_prod[SCALE_W +: DIST_W];

endmodule

`default_nettype wire

[src/ultrasonic_range_measure_unit.sv]
// Top level of the ultrasonic range measurement unit.
`timescale 1ns / 1ps
`default_nettype none

// Ultrasonic rangefinder echo timer. Every input transaction is one timebase
// tick carrying a start request and the sampled echo level; every tick gives
// exactly one output transaction with the trigger level, busy, done and the
// last distance in centimetres. A start while idle waits settle_ticks, then
// runs SAMPLES measurements (trigger pulse, wait for echo, count echo-high
// time in count periods, saturating at COUNT_BITS bits), averages the counts
// and scales by scale_q16 (Q16), saturating at 65535 cm. There is no echo
// timeout: an echo that never rises or never falls keeps the unit busy.
// Throughput is one transaction per clock while the output is taken. Each tick
// passes the sequencer, average (reciprocal multiply), scale multiply and output
// registers. The whole pipeline advances together, so s_axis_tready follows the
// output register being empty or taken. The user must write configuration only
// while idle; the block itself does not enforce it.
module ultrasonic_range_measure_unit
    import urm_pkg::*;
#(
    parameter int SAMPLES    = 3,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // tick input
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] start_req, [1] echo_level
    // tick result
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [0] trigger_level, [1] busy_res,
                                                        // [2] done_res, [18:3] distance_cm
    // configuration write port
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int SUM_W = COUNT_BITS + 2;

    t_cfg                r_cfg;
    logic                pipe_en;
    logic                accept;

    logic                seq_vld;
    t_flags              seq_flags;
    logic [SUM_W-1:0]    seq_sum;

    logic                dist_vld;
    t_flags              dist_flags;
    logic [DIST_W-1:0]   dist_cm;

    logic                r_out_vld;
    t_flags              r_out_flags;
    logic [DIST_W-1:0]   r_last_dist;

    // pipeline moves when the output register is empty or being taken
    assign pipe_en       = !r_out_vld || m_axis_tready;
    assign accept        = s_axis_tvalid && pipe_en;
    assign s_axis_tready = pipe_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks       <= SETTLE_RST;
            r_cfg.trigger_ticks      <= TRIGGER_RST;
            r_cfg.count_period_ticks <= PERIOD_RST;
            r_cfg.scale_q16          <= SCALE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_SETTLE:  r_cfg.settle_ticks       <= i_cfg_wdata[SETTLE_W-1:0];
                CFG_TRIGGER: r_cfg.trigger_ticks      <= i_cfg_wdata[TRIG_W-1:0];
                CFG_PERIOD:  r_cfg.count_period_ticks <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_SCALE:   r_cfg.scale_q16          <= i_cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    urm_seq #(
        .SAMPLES    (SAMPLES),
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (pipe_en),
        .i_accept     (accept),
        .i_start_req  (s_axis_tdata[0]),
        .i_echo_level (s_axis_tdata[1]),
        .i_cfg        (r_cfg),
        .o_vld        (seq_vld),
        .o_flags      (seq_flags),
        .o_sum        (seq_sum)
    );

    urm_dist #(
        .SAMPLES    (SAMPLES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_vld       (seq_vld),
        .i_flags     (seq_flags),
        .i_sum       (seq_sum),
        .i_scale_q16 (r_cfg.scale_q16),
        .o_vld       (dist_vld),
        .o_flags     (dist_flags),
        .o_dist      (dist_cm)
    );

    // output register; the held distance changes only on a done tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_out_flags <= '0;
            r_last_dist <= '0;
        end else if (pipe_en) begin
            r_out_vld   <= dist_vld;
            r_out_flags <= dist_flags;
            if (dist_vld && dist_flags.done_res) begin
                r_last_dist <= dist_cm;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_TDATA_W - DIST_W - 3)'(0),
                            r_last_dist,
                            r_out_flags.done_res,
                            r_out_flags.busy_res,
                            r_out_flags.trigger_level};

endmodule

`default_nettype wire
